/* rtl/core/ttd_pkg.sv */
// ---------------------------------------------------------------------------
// ttd_pkg
// Shared types and codes for the tick task dispatcher: item layouts, table
// entry layout, action and status codes, sequencer states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttd_pkg;

  localparam int ID_W  = 16;
  localparam int TIM_W = 16;
  localparam int OCC_W = 7;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_SET      = 2'd1,
    ACT_DELETE   = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    STAT_TICK_DONE    = 4'd0,
    STAT_UPDATED      = 4'd1,
    STAT_ADDED        = 4'd2,
    STAT_FULL_DROPPED = 4'd3,
    STAT_NULL_IGNORED = 4'd4,
    STAT_DELETED      = 4'd5,
    STAT_NOT_FOUND    = 4'd6,
    STAT_DISPATCHED   = 4'd7,
    STAT_NONE_READY   = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_TAIL_RD,
    S_TAIL_WR,
    S_APPEND,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    action_t            action;
    logic [ID_W-1:0]    task_id;
    logic [TIM_W-1:0]   start_delay;
    logic [TIM_W-1:0]   run_period;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    ready_id;
    logic               last;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIM_W-1:0]   delay;
    logic [TIM_W-1:0]   period;
    logic               ready;
  } entry_t;

  // flags and updated entries from the shared entry unit
  typedef struct packed {
    logic   id_match;
    logic   ready;
    logic   period_zero;
    entry_t tick_entry;
    entry_t rearm_entry;
  } unit_res_t;

endpackage

/* rtl/core/ttd_ram.sv */
// ---------------------------------------------------------------------------
// ttd_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ttd_entry_unit.sv */
// ---------------------------------------------------------------------------
// ttd_entry_unit
// Shared compare and decrement unit: matches an entry against the task id
// and builds the tick-updated and re-armed versions of the entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttd_entry_unit (
  input  ttd_pkg::entry_t              entry,
  input  logic                         tick_mode,
  input  logic [ttd_pkg::ID_W-1:0]     match_id,
  output ttd_pkg::unit_res_t           res
);

  logic [ttd_pkg::TIM_W-1:0] dec_in;
  logic [ttd_pkg::TIM_W-1:0] dec_out;
  logic                      delay_zero;

  // one decrementer: delay on tick, period when re-arming
  assign dec_in     = tick_mode ? entry.delay : entry.period;
  assign dec_out    = dec_in - ttd_pkg::TIM_W'(1);
  assign delay_zero = (entry.delay == '0);

  always_comb begin
    res             = '0;
    res.id_match    = (entry.id == match_id);
    res.ready       = entry.ready;
    res.period_zero = (entry.period == '0);

    // tick: mark due entries ready, count down the rest
    res.tick_entry  = entry;
    if (delay_zero) begin
      res.tick_entry.ready = 1'b1;
    end else begin
      res.tick_entry.delay = dec_out;
    end

    // re-arm after dispatch: clear flag, reload an expired delay
    res.rearm_entry       = entry;
    res.rearm_entry.ready = 1'b0;
    if (delay_zero) begin
      res.rearm_entry.delay = dec_out;
    end
  end

endmodule

/* rtl/core/tick_task_dispatcher.sv */
// ---------------------------------------------------------------------------
// tick_task_dispatcher
// Cooperative timer task table with tick, set, delete and dispatch items.
// ---------------------------------------------------------------------------
// The task table lives in one RAM walked by a small sequencer that visits
// each entry in a read state and then an evaluate state that writes it
// back through a shared compare/decrement unit. A dispatch waits in the
// evaluate state while a held result cannot go out. Moving the tail entry
// into the slot of a removed run-once task replaces the visit that tail
// entry would have had, so a moved-in entry waits for the next dispatch.
// Waiting on the response side lengthens an item. Requests are refused
// while an item is in progress. A dispatch gives one response per ready
// task it visits (last set on the final one), or a single none-ready
// response.
`timescale 1ns / 1ps

module tick_task_dispatcher #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ttd_pkg::in_item_t   req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ttd_pkg::out_item_t  rsp
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = ttd_pkg::OCC_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  ttd_pkg::fsm_state_t state, state_next;
  ttd_pkg::in_item_t   item;
  ttd_pkg::status_t    res_status;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       count;
  logic                pend_valid;
  logic [ttd_pkg::ID_W-1:0] pend_id;
  logic [CW-1:0]       pend_occ;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  ttd_pkg::entry_t     ram_wdata;
  logic                ram_re;
  logic [IW-1:0]       ram_raddr;
  ttd_pkg::entry_t     ram_rdata;

  ttd_pkg::unit_res_t  ur;
  ttd_pkg::entry_t     new_entry;
  logic                rsp_free;
  logic                can_emit;
  logic                in_range;
  logic                tail_is_idx;
  logic                eval_stall;
  logic                dispatch_hit;

  // task table storage
  ttd_ram #(
    .WIDTH ($bits(ttd_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared compare / decrement unit
  ttd_entry_unit u_unit (
    .entry     (ram_rdata),
    .tick_mode (item.action == ttd_pkg::ACT_TICK),
    .match_id  (item.task_id),
    .res       (ur)
  );

  // entry written by set, fresh or updated
  always_comb begin
    new_entry        = '0;
    new_entry.id     = item.task_id;
    new_entry.delay  = item.start_delay;
    new_entry.period = item.run_period;
    new_entry.ready  = 1'b0;
  end

  // common conditions
  assign rsp_free     = !rsp_valid || rsp_ready;
  assign can_emit     = !pend_valid || rsp_free;
  assign in_range     = (idx < count);
  assign tail_is_idx  = (idx == (count - CW'(1)));
  assign dispatch_hit = (item.action == ttd_pkg::ACT_DISPATCH) && ur.ready;
  assign eval_stall   = dispatch_hit && !can_emit;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ttd_pkg::S_IDLE: begin
        if (req_valid) begin
          if (req.action == ttd_pkg::ACT_SET && req.task_id == '0) begin
            state_next = ttd_pkg::S_DONE;
          end else begin
            state_next = ttd_pkg::S_READ;
          end
        end
      end
      ttd_pkg::S_READ: begin
        if (in_range) begin
          state_next = ttd_pkg::S_EVAL;
        end else if (item.action == ttd_pkg::ACT_SET) begin
          state_next = ttd_pkg::S_APPEND;
        end else begin
          state_next = ttd_pkg::S_DONE;
        end
      end
      ttd_pkg::S_EVAL: begin
        unique case (item.action)
          ttd_pkg::ACT_TICK: state_next = ttd_pkg::S_READ;
          ttd_pkg::ACT_SET: begin
            state_next = ur.id_match ? ttd_pkg::S_DONE : ttd_pkg::S_READ;
          end
          ttd_pkg::ACT_DELETE: begin
            if (!ur.id_match) begin
              state_next = ttd_pkg::S_READ;
            end else if (tail_is_idx) begin
              state_next = ttd_pkg::S_DONE;
            end else begin
              state_next = ttd_pkg::S_TAIL_RD;
            end
          end
          ttd_pkg::ACT_DISPATCH: begin
            if (eval_stall) begin
              state_next = ttd_pkg::S_EVAL;
            end else if (dispatch_hit && ur.period_zero && !tail_is_idx) begin
              state_next = ttd_pkg::S_TAIL_RD;
            end else begin
              state_next = ttd_pkg::S_READ;
            end
          end
          default: state_next = ttd_pkg::S_READ;
        endcase
      end
      ttd_pkg::S_TAIL_RD: state_next = ttd_pkg::S_TAIL_WR;
      ttd_pkg::S_TAIL_WR: begin
        state_next = (item.action == ttd_pkg::ACT_DELETE) ? ttd_pkg::S_DONE
                                                          : ttd_pkg::S_READ;
      end
      ttd_pkg::S_APPEND: state_next = ttd_pkg::S_DONE;
      ttd_pkg::S_DONE: begin
        if (rsp_free) begin
          state_next = ttd_pkg::S_IDLE;
        end
      end
      default: state_next = ttd_pkg::S_IDLE;
    endcase
  end

  // table port control and request handshake
  always_comb begin
    req_ready = (state == ttd_pkg::S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = idx[IW-1:0];
    ram_wdata = ur.tick_entry;
    ram_re    = 1'b0;
    ram_raddr = idx[IW-1:0];
    unique case (state)
      ttd_pkg::S_READ: begin
        ram_re = in_range;
      end
      ttd_pkg::S_EVAL: begin
        unique case (item.action)
          ttd_pkg::ACT_TICK: begin
            ram_we    = 1'b1;
            ram_wdata = ur.tick_entry;
          end
          ttd_pkg::ACT_SET: begin
            ram_we    = ur.id_match;
            ram_wdata = new_entry;
          end
          ttd_pkg::ACT_DISPATCH: begin
            ram_we    = dispatch_hit && !eval_stall && !ur.period_zero;
            ram_wdata = ur.rearm_entry;
          end
          default: ram_we = 1'b0;
        endcase
      end
      ttd_pkg::S_TAIL_RD: begin
        // count is already decremented, so it points at the old tail
        ram_re    = 1'b1;
        ram_raddr = count[IW-1:0];
      end
      ttd_pkg::S_TAIL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ttd_pkg::S_APPEND: begin
        ram_we    = (count < DEPTH_C);
        ram_waddr = count[IW-1:0];
        ram_wdata = new_entry;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // sequencer registers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ttd_pkg::S_IDLE;
      count      <= '0;
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ttd_pkg::S_IDLE: begin
          if (req_valid) begin
            item       <= req;
            idx        <= '0;
            pend_valid <= 1'b0;
            unique case (req.action)
              ttd_pkg::ACT_TICK:   res_status <= ttd_pkg::STAT_TICK_DONE;
              ttd_pkg::ACT_SET:    res_status <= ttd_pkg::STAT_NULL_IGNORED;
              ttd_pkg::ACT_DELETE: res_status <= ttd_pkg::STAT_NOT_FOUND;
              default:             res_status <= ttd_pkg::STAT_NONE_READY;
            endcase
          end
        end
        ttd_pkg::S_EVAL: begin
          unique case (item.action)
            ttd_pkg::ACT_TICK: idx <= idx + CW'(1);
            ttd_pkg::ACT_SET: begin
              if (ur.id_match) begin
                res_status <= ttd_pkg::STAT_UPDATED;
              end else begin
                idx <= idx + CW'(1);
              end
            end
            ttd_pkg::ACT_DELETE: begin
              if (ur.id_match) begin
                count      <= count - CW'(1);
                res_status <= ttd_pkg::STAT_DELETED;
              end else begin
                idx <= idx + CW'(1);
              end
            end
            ttd_pkg::ACT_DISPATCH: begin
              if (!ur.ready) begin
                idx <= idx + CW'(1);
              end else if (!eval_stall) begin
                // hand the held result on; it was not the final one
                if (pend_valid) begin
                  rsp_valid          <= 1'b1;
                  rsp.status         <= ttd_pkg::STAT_DISPATCHED;
                  rsp.ready_id       <= pend_id;
                  rsp.last           <= 1'b0;
                  rsp.occupancy      <= pend_occ;
                end
                pend_valid <= 1'b1;
                pend_id    <= ram_rdata.id;
                if (ur.period_zero) begin
                  count    <= count - CW'(1);
                  pend_occ <= count - CW'(1);
                  if (tail_is_idx) begin
                    idx <= idx + CW'(1);
                  end
                end else begin
                  pend_occ <= count;
                  idx      <= idx + CW'(1);
                end
              end
            end
            default: idx <= idx;
          endcase
        end
        ttd_pkg::S_TAIL_WR: begin
          idx <= idx + CW'(1);
        end
        ttd_pkg::S_APPEND: begin
          if (count < DEPTH_C) begin
            count      <= count + CW'(1);
            res_status <= ttd_pkg::STAT_ADDED;
          end else begin
            res_status <= ttd_pkg::STAT_FULL_DROPPED;
          end
        end
        ttd_pkg::S_DONE: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            rsp.last  <= 1'b1;
            if (pend_valid) begin
              rsp.status    <= ttd_pkg::STAT_DISPATCHED;
              rsp.ready_id  <= pend_id;
              rsp.occupancy <= pend_occ;
            end else begin
              rsp.status    <= res_status;
              rsp.ready_id  <= '0;
              rsp.occupancy <= count;
            end
          end
        end
        default: idx <= idx;
      endcase
    end
  end

endmodule

/* test/tick_task_dispatcher_test.sv */
// ---------------------------------------------------------------------------
// tick_task_dispatcher_test
// Self-checking bench for the tick task dispatcher. A short table of
// directed items covers the empty table, null and absent ids, the 16-bit
// extremes, re-arm and run-once removal. Random items follow in four
// handshake phases with table fill bursts. A local copy of the task table
// predicts the responses of untyped items, and all are compared in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tick_task_dispatcher_test;

  localparam int DEPTH = 32;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_LINES = 60;

  typedef struct {
    ttd_pkg::in_item_t         item;
    bit                        typed;
    ttd_pkg::status_t          exp_status;
    logic [ttd_pkg::OCC_W-1:0] exp_occ;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  ttd_pkg::in_item_t  req = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  ttd_pkg::out_item_t rsp;

  // local copy of the task table
  logic [ttd_pkg::ID_W-1:0]  tbl_id     [DEPTH];
  logic [ttd_pkg::TIM_W-1:0] tbl_delay  [DEPTH];
  logic [ttd_pkg::TIM_W-1:0] tbl_period [DEPTH];
  logic                      tbl_ready  [DEPTH];
  int                        tbl_count = 0;

  // responses of the item being predicted
  ttd_pkg::status_t          step_status [64];
  logic [ttd_pkg::ID_W-1:0]  step_id     [64];
  logic [ttd_pkg::OCC_W-1:0] step_occ    [64];
  int                        step_n;

  ttd_pkg::out_item_t awaited_rsp [$];
  int                 mismatches = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  dir_row_t           dir_rows [17];

  tick_task_dispatcher #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_LINES) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic void note_result(input ttd_pkg::status_t s,
                                      input logic [ttd_pkg::ID_W-1:0] id);
    step_status[step_n] = s;
    step_id[step_n]     = id;
    step_occ[step_n]    = tbl_count[ttd_pkg::OCC_W-1:0];
    step_n++;
  endfunction

  function automatic int find_task(input logic [ttd_pkg::ID_W-1:0] id);
    int i;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // packed removal: the tail entry moves into the freed slot
  function automatic void drop_entry(input int i);
    int tail;
    tail = tbl_count - 1;
    if (i != tail) begin
      tbl_id[i]     = tbl_id[tail];
      tbl_delay[i]  = tbl_delay[tail];
      tbl_period[i] = tbl_period[tail];
      tbl_ready[i]  = tbl_ready[tail];
    end
    tbl_count = tail;
  endfunction

  // apply one transfer to the table, optionally queue its responses
  task automatic table_step(input ttd_pkg::in_item_t it, input bit queue_rsp);
    int                 i;
    int                 pos;
    ttd_pkg::out_item_t r;
    step_n = 0;
    case (it.action)
      ttd_pkg::ACT_TICK: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_delay[i] == '0) tbl_ready[i] = 1'b1;
          else tbl_delay[i] = tbl_delay[i] - 1'b1;
        end
        note_result(ttd_pkg::STAT_TICK_DONE, '0);
      end
      ttd_pkg::ACT_SET: begin
        pos = find_task(it.task_id);
        if (it.task_id == '0) begin
          note_result(ttd_pkg::STAT_NULL_IGNORED, '0);
        end else if (pos >= 0) begin
          tbl_delay[pos]  = it.start_delay;
          tbl_period[pos] = it.run_period;
          tbl_ready[pos]  = 1'b0;
          note_result(ttd_pkg::STAT_UPDATED, '0);
        end else if (tbl_count < DEPTH) begin
          tbl_id[tbl_count]     = it.task_id;
          tbl_delay[tbl_count]  = it.start_delay;
          tbl_period[tbl_count] = it.run_period;
          tbl_ready[tbl_count]  = 1'b0;
          tbl_count++;
          note_result(ttd_pkg::STAT_ADDED, '0);
        end else begin
          note_result(ttd_pkg::STAT_FULL_DROPPED, '0);
        end
      end
      ttd_pkg::ACT_DELETE: begin
        pos = find_task(it.task_id);
        if (pos >= 0) begin
          drop_entry(pos);
          note_result(ttd_pkg::STAT_DELETED, '0);
        end else begin
          note_result(ttd_pkg::STAT_NOT_FOUND, '0);
        end
      end
      default: begin
        // moved-in entries are skipped until the next dispatch
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_ready[i]) begin
            r.ready_id = tbl_id[i];
            if (tbl_period[i] == '0) begin
              drop_entry(i);
            end else begin
              tbl_ready[i] = 1'b0;
              if (tbl_delay[i] == '0) tbl_delay[i] = tbl_period[i] - 1'b1;
            end
            note_result(ttd_pkg::STAT_DISPATCHED, r.ready_id);
          end
        end
        if (step_n == 0) note_result(ttd_pkg::STAT_NONE_READY, '0);
      end
    endcase
    if (queue_rsp) begin
      for (i = 0; i < step_n; i++) begin
        r.status    = step_status[i];
        r.ready_id  = step_id[i];
        r.last      = (i == step_n - 1);
        r.occupancy = step_occ[i];
        awaited_rsp.push_back(r);
      end
    end
  endtask

  // one request transfer; typed rows carry their own expected response
  task automatic send_item(input ttd_pkg::in_item_t it, input bit typed,
                           input ttd_pkg::status_t exp_status,
                           input logic [ttd_pkg::OCC_W-1:0] exp_occ);
    ttd_pkg::out_item_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    table_step(it, !typed);
    if (typed) begin
      r.status    = exp_status;
      r.ready_id  = '0;
      r.last      = 1'b1;
      r.occupancy = exp_occ;
      awaited_rsp.push_back(r);
    end
  endtask

  function automatic dir_row_t make_row(input ttd_pkg::action_t a,
                                        input logic [ttd_pkg::ID_W-1:0] id,
                                        input logic [ttd_pkg::TIM_W-1:0] dly,
                                        input logic [ttd_pkg::TIM_W-1:0] per,
                                        input bit typed,
                                        input ttd_pkg::status_t st,
                                        input logic [ttd_pkg::OCC_W-1:0] occ);
    dir_row_t row;
    row.item.action      = a;
    row.item.task_id     = id;
    row.item.start_delay = dly;
    row.item.run_period  = per;
    row.typed            = typed;
    row.exp_status       = st;
    row.exp_occ          = occ;
    return row;
  endfunction

  // weighted random item, mostly small ids and short delays
  function automatic ttd_pkg::in_item_t random_item();
    ttd_pkg::in_item_t it;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 30) it.action = ttd_pkg::ACT_TICK;
    else if (pick < 65) it.action = ttd_pkg::ACT_SET;
    else if (pick < 80) it.action = ttd_pkg::ACT_DELETE;
    else it.action = ttd_pkg::ACT_DISPATCH;
    pick = $urandom_range(99);
    if (pick < 8) it.task_id = '0;
    else if (pick < 18) it.task_id = ttd_pkg::ID_W'($urandom_range(65535));
    else it.task_id = ttd_pkg::ID_W'($urandom_range(40, 1));
    if (it.action == ttd_pkg::ACT_DELETE && tbl_count > 0 && $urandom_range(99) < 70) begin
      it.task_id = tbl_id[$urandom_range(tbl_count - 1)];
    end
    if ($urandom_range(99) < 75) it.start_delay = ttd_pkg::TIM_W'($urandom_range(3));
    else it.start_delay = ttd_pkg::TIM_W'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 40) it.run_period = '0;
    else if (pick < 80) it.run_period = ttd_pkg::TIM_W'($urandom_range(4, 1));
    else it.run_period = ttd_pkg::TIM_W'($urandom_range(65535));
    return it;
  endfunction

  // fill the table, then push past full
  task automatic fill_table();
    ttd_pkg::in_item_t it;
    int                guard;
    int                k;
    guard = 0;
    it.action = ttd_pkg::ACT_SET;
    while (tbl_count < DEPTH && guard < 200) begin
      it.task_id     = ttd_pkg::ID_W'($urandom_range(65535, 100));
      it.start_delay = ttd_pkg::TIM_W'($urandom_range(2));
      it.run_period  = ttd_pkg::TIM_W'($urandom_range(3));
      send_item(it, 1'b0, ttd_pkg::STAT_TICK_DONE, '0);
      guard++;
    end
    for (k = 0; k < 4; k++) begin
      it.task_id = ttd_pkg::ID_W'($urandom_range(65535, 100));
      if (k == 3) it.task_id = tbl_id[$urandom_range(tbl_count - 1)];
      send_item(it, 1'b0, ttd_pkg::STAT_TICK_DONE, '0);
    end
  endtask

  // response side stalls
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each response transfer with the oldest prediction
  always @(posedge clk) begin
    ttd_pkg::out_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch($sformatf("unexpected response status %0d id %0h last %0b occ %0d",
                                  rsp.status, rsp.ready_id, rsp.last, rsp.occupancy));
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp !== want) begin
          report_mismatch($sformatf("got status %0d id %0h last %0b occ %0d, want %0d %0h %0b %0d",
                                    rsp.status, rsp.ready_id, rsp.last, rsp.occupancy,
                                    want.status, want.ready_id, want.last, want.occupancy));
        end
      end
    end
  end

  // main stimulus
  initial begin
    int ph;
    int k;
    dir_rows[0]  = make_row(ttd_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                            ttd_pkg::STAT_TICK_DONE, 7'd0);
    dir_rows[1]  = make_row(ttd_pkg::ACT_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                            ttd_pkg::STAT_NONE_READY, 7'd0);
    dir_rows[2]  = make_row(ttd_pkg::ACT_SET, 16'h0000, 16'hffff, 16'hffff, 1'b1,
                            ttd_pkg::STAT_NULL_IGNORED, 7'd0);
    dir_rows[3]  = make_row(ttd_pkg::ACT_DELETE, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                            ttd_pkg::STAT_NOT_FOUND, 7'd0);
    dir_rows[4]  = make_row(ttd_pkg::ACT_SET, 16'hffff, 16'h0000, 16'h0000, 1'b1,
                            ttd_pkg::STAT_ADDED, 7'd1);
    dir_rows[5]  = make_row(ttd_pkg::ACT_SET, 16'h0001, 16'hffff, 16'hffff, 1'b1,
                            ttd_pkg::STAT_ADDED, 7'd2);
    dir_rows[6]  = make_row(ttd_pkg::ACT_SET, 16'h0002, 16'h0001, 16'h0001, 1'b1,
                            ttd_pkg::STAT_ADDED, 7'd3);
    dir_rows[7]  = make_row(ttd_pkg::ACT_SET, 16'h0003, 16'h0000, 16'h0005, 1'b1,
                            ttd_pkg::STAT_ADDED, 7'd4);
    dir_rows[8]  = make_row(ttd_pkg::ACT_SET, 16'h0002, 16'h0000, 16'h0001, 1'b1,
                            ttd_pkg::STAT_UPDATED, 7'd4);
    dir_rows[9]  = make_row(ttd_pkg::ACT_TICK, 16'hffff, 16'hffff, 16'hffff, 1'b1,
                            ttd_pkg::STAT_TICK_DONE, 7'd4);
    // run-once removal pulls the tail in, then period-one re-arm
    dir_rows[10] = make_row(ttd_pkg::ACT_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                            ttd_pkg::STAT_TICK_DONE, 7'd0);
    // the moved-in entry is picked up on this pass
    dir_rows[11] = make_row(ttd_pkg::ACT_DISPATCH, 16'hffff, 16'hffff, 16'hffff, 1'b0,
                            ttd_pkg::STAT_TICK_DONE, 7'd0);
    dir_rows[12] = make_row(ttd_pkg::ACT_DELETE, 16'h0001, 16'h0000, 16'h0000, 1'b1,
                            ttd_pkg::STAT_DELETED, 7'd2);
    dir_rows[13] = make_row(ttd_pkg::ACT_DELETE, 16'h0001, 16'h0000, 16'h0000, 1'b1,
                            ttd_pkg::STAT_NOT_FOUND, 7'd2);
    dir_rows[14] = make_row(ttd_pkg::ACT_SET, 16'h0002, 16'hffff, 16'h0000, 1'b1,
                            ttd_pkg::STAT_UPDATED, 7'd2);
    dir_rows[15] = make_row(ttd_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                            ttd_pkg::STAT_TICK_DONE, 7'd2);
    dir_rows[16] = make_row(ttd_pkg::ACT_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                            ttd_pkg::STAT_NONE_READY, 7'd2);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (k = 0; k < 17; k++) begin
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].exp_status,
                dir_rows[k].exp_occ);
    end

    // random phases with different handshake pressure
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase
      if (ph == 0 || ph == 3) fill_table();
      for (k = 0; k < 20; k++) begin
        send_item(random_item(), 1'b0, ttd_pkg::STAT_TICK_DONE, '0);
      end
    end
    req_valid <= 1'b0;

    // drain, then watch for stray responses
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop, well past the slowest legal run
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
